// File: rtl/core/escape_time_fractal_iterator_macros.svh
// Assertion macros for the escape-time fractal iterator.
// Used by the top level only; no other dependencies.
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_MACROS_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ETF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("etf assertion failed");
// next-cycle implication
`define ETF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("etf assertion failed");
`else
`define ETF_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ETF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/etf_pkg.sv
// Shared types and constants for the escape-time fractal iterator.
// No dependencies; imported by every module of the block.
`default_nettype none

package etf_pkg;

  // number formats
  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 28;
  localparam int ITER_BITS = 16;
  localparam int PROD_W    = 2 * COORD_W;

  // APB register map
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_MODE      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SEED_REAL = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SEED_IMAG = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_ITER  = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic [ITER_BITS-1:0]      iter_t;

  localparam iter_t MAX_ITER_RST = iter_t'(256);

  // fixed-point constants
  localparam coord_t Q_QUARTER = coord_t'(1) << (FRAC_BITS - 2);
  localparam coord_t Q_ONE     = coord_t'(1) << FRAC_BITS;
  localparam coord_t BOX_LO_X  = -(coord_t'(5) << (FRAC_BITS - 2));
  localparam coord_t BOX_HI_X  = coord_t'(3) << (FRAC_BITS - 3);
  localparam coord_t BOX_LIM_Y = coord_t'(3) << (FRAC_BITS - 2);
  localparam coord_t BOX_NEG_Y = -(coord_t'(3) << (FRAC_BITS - 2));
  localparam coord_t BULB_R2   = coord_t'(1) << (FRAC_BITS - 4);

  // |z|^2 limit of 4 at the scale of an exact product
  localparam logic [PROD_W-1:0] ESC_LIMIT =
    {{(PROD_W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

  typedef struct packed {
    logic   mode;
    coord_t seed_real;
    coord_t seed_imag;
    iter_t  max_iter;
  } cfg_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
  } in_item_t;

  typedef struct packed {
    iter_t escape_count;
    logic  trapped;
  } out_item_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } core_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/escape_time_fractal_iterator.sv
// Top level of the escape-time fractal iterator: handshake, result register.
// Depends on etf_pkg, etf_cfg, etf_core and the assertion macro header.
`default_nettype none

// Escape-time iterator for Mandelbrot (mode 0) and Julia (mode 1) sets in
// signed Q4.28. One point is in flight at a time; in_stall is high from
// acceptance until the result is handed to the output register, which then
// lets the next point in while the result waits. All arithmetic runs on one
// shared 32x32 multiplier: each iteration steps through x*x, y*y, x*y and
// the z update, with the |z|^2 > 4 check folded into the x*y step. Mandelbrot
// points first take a box test around the main cardioid and period-2 bulb,
// and a trap test when they lie in that box; a trapped point returns
// trapped=1 and escape_count=0. A finished result waits as long as the output
// register stays full and stalled.
module escape_time_fractal_iterator (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire etf_pkg::in_item_t              in_data,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output etf_pkg::out_item_t                  out_data,
  // configuration
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [etf_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [etf_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [etf_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);
  import etf_pkg::*;

`include "escape_time_fractal_iterator_macros.svh"

  cfg_t       cfg;
  core_stat_t stat;
  out_item_t  core_res;
  logic       start;
  logic       res_ready;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;

  etf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  etf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .start     (start),
    .item      (in_data),
    .res_ready (res_ready),
    .stat      (stat),
    .res       (core_res)
  );

  // input transaction
  assign in_stall = !stat.idle;
  assign start    = in_valid && !in_stall;

  // output register: loads when empty or being drained
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (stat.res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = core_res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `ETF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `ETF_ASSERT_NEXT(a_result_held, clk, rst_n, stat.res_valid && !res_ready, stat.res_valid)
  `ETF_ASSERT_SAME(a_trap_no_count, clk, rst_n, stat.res_valid && core_res.trapped, core_res.escape_count == '0)

endmodule

`default_nettype wire

// File: rtl/core/etf_mul.sv
// Shared signed multiplier with a registered full-width product.
// Depends on etf_pkg.
`default_nettype none

module etf_mul (
  input  wire logic           clk,
  input  wire etf_pkg::coord_t a,
  input  wire etf_pkg::coord_t b,
  output etf_pkg::prod_t      prod_r
);
  import etf_pkg::*;

  // exact product, registered
  always_ff @(posedge clk) begin
    prod_r <= prod_t'(a) * prod_t'(b);
  end

endmodule

`default_nettype wire

// File: rtl/core/etf_core.sv
// Sequencer and datapath: trap test and z = z^2 + addend iteration on one
// shared multiplier. Depends on etf_pkg and etf_mul.
`default_nettype none

module etf_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire etf_pkg::cfg_t     cfg,
  input  wire logic              start,
  input  wire etf_pkg::in_item_t item,
  input  wire logic              res_ready,
  output etf_pkg::core_stat_t    stat,
  output etf_pkg::out_item_t     res
);
  import etf_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0_0000_0000_0001,
    S_BOX   = 13'b0_0000_0000_0010,
    S_TYY   = 13'b0_0000_0000_0100,
    S_TXM   = 13'b0_0000_0000_1000,
    S_TQ    = 13'b0_0000_0001_0000,
    S_TLHS  = 13'b0_0000_0010_0000,
    S_TCMP  = 13'b0_0000_0100_0000,
    S_TBULB = 13'b0_0000_1000_0000,
    S_XX    = 13'b0_0001_0000_0000,
    S_YY    = 13'b0_0010_0000_0000,
    S_XY    = 13'b0_0100_0000_0000,
    S_UPD   = 13'b0_1000_0000_0000,
    S_DONE  = 13'b1_0000_0000_0000
  } state_t;

  state_t    state_r, state_nxt;
  coord_t    x_r, x_nxt, y_r, y_nxt;
  coord_t    ax_r, ax_nxt, ay_r, ay_nxt;
  coord_t    cx_r, cx_nxt, cy_r, cy_nxt;
  coord_t    y2_r, y2_nxt, q_r, q_nxt;
  prod_t     xx_r, xx_nxt, yy_r, yy_nxt;
  iter_t     i_r, i_nxt;
  out_item_t res_r, res_nxt;

  coord_t mul_a, mul_b;
  prod_t  prod;
  coord_t prod_q, xx_q, yy_q;
  coord_t xm, x1, q_sum, r_sum, nx, ny;
  logic   in_box, escaped;
  logic [PROD_W:0] mag_sum;
  iter_t  iter_inc;
  logic   max_zero;

  etf_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  // truncated products and helper sums
  assign prod_q   = prod[FRAC_BITS+COORD_W-1:FRAC_BITS];
  assign xx_q     = xx_r[FRAC_BITS+COORD_W-1:FRAC_BITS];
  assign yy_q     = yy_r[FRAC_BITS+COORD_W-1:FRAC_BITS];
  assign xm       = cx_r - Q_QUARTER;
  assign x1       = cx_r + Q_ONE;
  assign q_sum    = prod_q + y2_r;
  assign r_sum    = prod_q + y2_r;
  assign nx       = xx_q - yy_q + ax_r;
  assign ny       = (prod_q <<< 1) + ay_r;
  assign iter_inc = i_r + 1'b1;
  assign max_zero = (cfg.max_iter == '0);

  // box around cardioid and bulb; nothing wraps inside it
  assign in_box = (cx_r >= BOX_LO_X) && (cx_r <= BOX_HI_X) &&
                  (cy_r >= BOX_NEG_Y) && (cy_r <= BOX_LIM_Y);

  // exact |z|^2 > 4 from the two full squares
  assign mag_sum = {1'b0, xx_r} + {1'b0, prod};
  assign escaped = mag_sum > {1'b0, ESC_LIMIT};

  // multiplier operand select
  always_comb begin
    mul_a = x_r;
    mul_b = x_r;
    case (state_r)
      S_TYY: begin
        mul_a = cy_r;
        mul_b = cy_r;
      end
      S_TXM: begin
        mul_a = xm;
        mul_b = xm;
      end
      S_TLHS: begin
        mul_a = q_r;
        mul_b = q_r + xm;
      end
      S_TCMP: begin
        mul_a = x1;
        mul_b = x1;
      end
      S_YY: begin
        mul_a = y_r;
        mul_b = y_r;
      end
      S_XY: begin
        mul_a = x_r;
        mul_b = y_r;
      end
      default: begin
        mul_a = x_r;
        mul_b = x_r;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    ax_nxt    = ax_r;
    ay_nxt    = ay_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    y2_nxt    = y2_r;
    q_nxt     = q_r;
    xx_nxt    = xx_r;
    yy_nxt    = yy_r;
    i_nxt     = i_r;
    res_nxt   = res_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cx_nxt  = item.point_x;
          cy_nxt  = item.point_y;
          i_nxt   = '0;
          res_nxt = '0;
          if (!cfg.mode) begin
            x_nxt     = '0;
            y_nxt     = '0;
            ax_nxt    = item.point_x;
            ay_nxt    = item.point_y;
            state_nxt = S_BOX;
          end else begin
            x_nxt     = item.point_x;
            y_nxt     = item.point_y;
            ax_nxt    = cfg.seed_real;
            ay_nxt    = cfg.seed_imag;
            state_nxt = max_zero ? S_DONE : S_XX;
          end
        end
      end
      S_BOX: begin
        if (in_box) begin
          state_nxt = S_TYY;
        end else begin
          state_nxt = max_zero ? S_DONE : S_XX;
        end
      end
      S_TYY: state_nxt = S_TXM;
      S_TXM: begin
        y2_nxt    = prod_q;
        state_nxt = S_TQ;
      end
      S_TQ: begin
        q_nxt     = q_sum;
        state_nxt = S_TLHS;
      end
      S_TLHS: state_nxt = S_TCMP;
      // cardioid: q*(q+xm) < y^2/4
      S_TCMP: begin
        if (prod_q < (y2_r >>> 2)) begin
          res_nxt.trapped = 1'b1;
          state_nxt       = S_DONE;
        end else begin
          state_nxt = S_TBULB;
        end
      end
      // period-2 bulb: (x+1)^2 + y^2 < 1/16
      S_TBULB: begin
        if (r_sum < BULB_R2) begin
          res_nxt.trapped = 1'b1;
          state_nxt       = S_DONE;
        end else begin
          state_nxt = max_zero ? S_DONE : S_XX;
        end
      end
      S_XX: state_nxt = S_YY;
      S_YY: begin
        xx_nxt    = prod;
        state_nxt = S_XY;
      end
      S_XY: begin
        if (escaped) begin
          res_nxt.escape_count = iter_inc;
          i_nxt                = iter_inc;
          state_nxt            = S_DONE;
        end else begin
          yy_nxt    = prod;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        x_nxt = nx;
        y_nxt = ny;
        i_nxt = iter_inc;
        state_nxt = (iter_inc == cfg.max_iter) ? S_DONE : S_XX;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state and iteration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      x_r     <= '0;
      y_r     <= '0;
      i_r     <= '0;
    end else begin
      state_r <= state_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      i_r     <= i_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    ax_r  <= ax_nxt;
    ay_r  <= ay_nxt;
    cx_r  <= cx_nxt;
    cy_r  <= cy_nxt;
    y2_r  <= y2_nxt;
    q_r   <= q_nxt;
    xx_r  <= xx_nxt;
    yy_r  <= yy_nxt;
    res_r <= res_nxt;
  end

  assign stat.idle      = (state_r == S_IDLE);
  assign stat.res_valid = (state_r == S_DONE);
  assign res            = res_r;

endmodule

`default_nettype wire

// File: rtl/core/etf_cfg.sv
// APB configuration registers: mode, Julia seed and iteration limit.
// Depends on etf_pkg.
`default_nettype none

module etf_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [etf_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [etf_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [etf_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                    pready,
  output etf_pkg::cfg_t                           cfg
);
  import etf_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_MODE:      cfg_nxt.mode      = pwdata[0];
        REG_SEED_REAL: cfg_nxt.seed_real = pwdata[COORD_W-1:0];
        REG_SEED_IMAG: cfg_nxt.seed_imag = pwdata[COORD_W-1:0];
        REG_MAX_ITER:  cfg_nxt.max_iter  = pwdata[ITER_BITS-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= 1'b0;
      cfg_r.seed_real <= '0;
      cfg_r.seed_imag <= '0;
      cfg_r.max_iter  <= MAX_ITER_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_MODE:      prdata = {{(APB_DATA_W-1){1'b0}}, cfg_r.mode};
      REG_SEED_REAL: prdata = cfg_r.seed_real;
      REG_SEED_IMAG: prdata = cfg_r.seed_imag;
      REG_MAX_ITER:  prdata = {{(APB_DATA_W-ITER_BITS){1'b0}}, cfg_r.max_iter};
      default:       prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: test/escape_time_checker.sv
// Checker for the escape-time fractal iterator: watches the point, result and
// register ports, predicts each escape result and compares it field by field.
// Depends on etf_pkg for the port types and register indexes.
module escape_time_checker
  import etf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    errors,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Q4.28 constants of the trap test and the escape radius
  localparam coord_t QUARTER    = coord_t'(1) << (FRAC_BITS - 2);
  localparam coord_t UNIT       = coord_t'(1) << FRAC_BITS;
  localparam coord_t TRAP_X_LO  = -(coord_t'(5) << (FRAC_BITS - 2));
  localparam coord_t TRAP_X_HI  = coord_t'(3) << (FRAC_BITS - 3);
  localparam coord_t TRAP_Y_LIM = coord_t'(3) << (FRAC_BITS - 2);
  localparam coord_t BULB_LIM   = coord_t'(1) << (FRAC_BITS - 4);
  localparam logic [63:0] RADIUS_SQ_LIMIT = 64'd1 << (2 * FRAC_BITS + 2);

  // register copies
  logic   cfg_mode;
  coord_t cfg_seed_re;
  coord_t cfg_seed_im;
  iter_t  cfg_max_iter;

  // last orbit position and checks done, as the block keeps them
  coord_t z_re;
  coord_t z_im;
  iter_t  checks_done;

  out_item_t expected_escapes[$];
  int        fail_count = 0;

  assign errors = fail_count;

  // floor(a*b / 2^FRAC_BITS), wrapped to the coordinate width
  function automatic coord_t fx_mul(coord_t a, coord_t b);
    longint prod;
    prod = longint'(a) * longint'(b);
    return coord_t'(prod >>> FRAC_BITS);
  endfunction

  // exact |z|^2 > 4
  function automatic bit beyond_radius(coord_t x, coord_t y);
    longint      mx;
    longint      my;
    logic [63:0] sum;
    mx  = (x < 0) ? -longint'(x) : longint'(x);
    my  = (y < 0) ? -longint'(y) : longint'(y);
    sum = unsigned'(mx * mx) + unsigned'(my * my);
    return sum > RADIUS_SQ_LIMIT;
  endfunction

  // main cardioid or period-2 bulb, tested only inside the bounding box
  function automatic bit in_main_bulbs(coord_t x, coord_t y);
    coord_t y2;
    coord_t xm;
    coord_t rad;
    coord_t lhs;
    coord_t x1;
    coord_t r2;
    if (x < TRAP_X_LO || x > TRAP_X_HI || y > TRAP_Y_LIM || y < -TRAP_Y_LIM) return 1'b0;
    y2  = fx_mul(y, y);
    xm  = x - QUARTER;
    rad = fx_mul(xm, xm) + y2;
    lhs = fx_mul(rad, coord_t'(rad + xm));
    if (lhs < (y2 >>> 2)) return 1'b1;
    x1 = x + UNIT;
    r2 = fx_mul(x1, x1) + y2;
    return r2 < BULB_LIM;
  endfunction

  // escape count and trap flag for one point under the current registers
  function automatic out_item_t predict_escape(in_item_t p);
    coord_t      x;
    coord_t      y;
    coord_t      add_re;
    coord_t      add_im;
    coord_t      nx;
    coord_t      xy;
    int unsigned i;
    int unsigned count;
    out_item_t   res;
    res = '0;
    if (!cfg_mode) begin
      z_re        = '0;
      z_im        = '0;
      checks_done = '0;
      if (in_main_bulbs(p.point_x, p.point_y)) begin
        res.trapped = 1'b1;
        return res;
      end
      x      = '0;
      y      = '0;
      add_re = p.point_x;
      add_im = p.point_y;
    end else begin
      x      = p.point_x;
      y      = p.point_y;
      add_re = cfg_seed_re;
      add_im = cfg_seed_im;
    end
    count = 0;
    for (i = 0; i < cfg_max_iter; i++) begin
      if (beyond_radius(x, y)) begin
        count = i + 1;
        break;
      end
      nx = fx_mul(x, x) - fx_mul(y, y) + add_re;
      xy = fx_mul(x, y);
      y  = xy + xy + add_im;
      x  = nx;
    end
    z_re             = x;
    z_im             = y;
    checks_done      = iter_t'((count != 0) ? count : i);
    res.escape_count = iter_t'(count);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      cfg_mode     = 1'b0;
      cfg_seed_re  = '0;
      cfg_seed_im  = '0;
      cfg_max_iter = iter_t'(256);
      z_re         = '0;
      z_im         = '0;
      checks_done  = '0;
      expected_escapes.delete();
    end else begin
      // register write transaction
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_ADDR_W-1:2])
          REG_MODE:      cfg_mode     = pwdata[0];
          REG_SEED_REAL: cfg_seed_re  = coord_t'(pwdata);
          REG_SEED_IMAG: cfg_seed_im  = coord_t'(pwdata);
          REG_MAX_ITER:  cfg_max_iter = iter_t'(pwdata);
          default: ;
        endcase
      end
      // result transaction against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_escapes.size() == 0) begin
          $error("result transaction with nothing expected (count %0d, trapped %0b)",
                 out_data.escape_count, out_data.trapped);
          fail_count++;
        end else begin
          want = expected_escapes.pop_front();
          if (out_data.escape_count !== want.escape_count) begin
            $error("escape_count: expected %0d, got %0d",
                   want.escape_count, out_data.escape_count);
            fail_count++;
          end
          if (out_data.trapped !== want.trapped) begin
            $error("trapped: expected %0b, got %0b", want.trapped, out_data.trapped);
            fail_count++;
          end
        end
      end
      // point transaction
      if (in_valid && !in_stall) expected_escapes.push_back(predict_escape(in_data));
    end
    pending <= expected_escapes.size();
  end

endmodule

// File: test/tb.sv
// Testbench top for the escape-time fractal iterator: clock, reset, register
// writes, point stimulus, result back-pressure and the final verdict.
// Depends on etf_pkg, the block itself and escape_time_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import etf_pkg::*;

  localparam coord_t C_MIN = coord_t'(32'h8000_0000);
  localparam coord_t C_MAX = coord_t'(32'h7FFF_FFFF);

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    errors;
  int                    pending;
  int                    burst_left = 0;
  int unsigned           stall_cycle = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  escape_time_fractal_iterator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  escape_time_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .errors    (errors),
    .pending   (pending)
  );

  // result back-pressure: free, random, periodic and light random windows
  always @(posedge clk) begin
    case (stall_cycle[9:8])
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= ($urandom_range(1, 0) == 0);
      2'd2:    out_stall <= (stall_cycle[3:0] < 4'd5);
      default: out_stall <= ($urandom_range(3, 0) == 0);
    endcase
    stall_cycle++;
  end

  function automatic coord_t q(real r);
    return coord_t'($rtoi(r * 268435456.0));
  endfunction

  function automatic coord_t rand_span(coord_t lo, coord_t hi);
    return lo + coord_t'($urandom_range(int'(hi - lo), 0));
  endfunction

  function automatic coord_t corner_value();
    case ($urandom_range(7, 0))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return '0;
      3:       return coord_t'(1);
      4:       return -coord_t'(1);
      5:       return q(2.0);
      6:       return q(-2.0);
      default: return q(0.75);
    endcase
  endfunction

  // mostly the interesting region, some near the traps, some anywhere, some at corner values
  function automatic in_item_t pick_point();
    in_item_t    p;
    int unsigned sel;
    sel = $urandom_range(99, 0);
    if (sel < 60) begin
      p.point_x = rand_span(q(-2.25), q(1.25));
      p.point_y = rand_span(q(-1.5), q(1.5));
    end else if (sel < 75) begin
      p.point_x = rand_span(q(-1.3), q(0.4));
      p.point_y = rand_span(q(-0.8), q(0.8));
    end else if (sel < 90) begin
      p.point_x = coord_t'($urandom);
      p.point_y = coord_t'($urandom);
    end else begin
      p.point_x = corner_value();
      p.point_y = corner_value();
    end
    return p;
  endfunction

  // one point transaction, sent in bursts with random gaps between them
  task automatic send_point(input coord_t x, input coord_t y);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(12, 1);
    end
    in_valid        <= 1'b1;
    in_data.point_x <= x;
    in_data.point_y <= y;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  task automatic send_random(input int n);
    in_item_t p;
    repeat (n) begin
      p = pick_point();
      send_point(p.point_x, p.point_y);
    end
  endtask

  // stop sending and wait for every predicted result
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Mandelbrot at reset settings: traps, box edges, cusp, real-axis ends, extremes
    send_point('0, '0);
    send_point(q(-1.0), '0);
    send_point(q(-0.1), q(0.1));
    send_point(q(-1.25), '0);
    send_point(q(0.375), '0);
    send_point(q(0.375) + coord_t'(1), '0);
    send_point(q(-0.75), q(0.75));
    send_point('0, q(-0.75));
    send_point(q(0.25), '0);
    send_point(q(-2.0), '0);
    send_point(q(2.0), '0);
    send_point(C_MIN, C_MIN);
    send_point(C_MAX, C_MAX);
    send_point(C_MAX, C_MIN);
    send_point('0, C_MAX);
    drain();

    // single check: z is still zero, so nothing escapes
    write_reg(REG_MAX_ITER, 32'd1);
    send_point(q(0.5), q(0.5));
    drain();

    // no checks at all; traps still apply
    write_reg(REG_MAX_ITER, 32'd0);
    send_point(C_MIN, C_MIN);
    send_point('0, '0);
    drain();

    // Julia with zero seed; only the low mode bit counts
    write_reg(REG_MODE, 32'h0000_0003);
    write_reg(REG_SEED_REAL, 32'd0);
    write_reg(REG_SEED_IMAG, 32'd0);
    write_reg(REG_MAX_ITER, 32'd16);
    send_point(C_MIN, C_MIN);
    send_point(q(2.0), '0);
    send_point('0, q(-2.0));
    send_point('0, '0);
    send_point(C_MIN, C_MAX);
    drain();

    // Julia around a classic seed
    write_reg(REG_SEED_REAL, 32'(q(-0.8)));
    write_reg(REG_SEED_IMAG, 32'(q(0.156)));
    write_reg(REG_MAX_ITER, 32'd64);
    send_random(200);
    drain();

    // Julia with extreme seeds, short limit
    write_reg(REG_SEED_REAL, 32'(C_MIN));
    write_reg(REG_SEED_IMAG, 32'(C_MAX));
    write_reg(REG_MAX_ITER, 32'd8);
    send_random(50);
    drain();

    // Mandelbrot; upper bits of both writes are dropped
    write_reg(REG_MODE, 32'hFFFF_FFFE);
    write_reg(REG_MAX_ITER, 32'hABCD_0030);
    send_random(300);
    drain();

    write_reg(REG_MAX_ITER, 32'd256);
    send_random(100);
    drain();

    // Julia with random seeds and limits
    write_reg(REG_MODE, 32'd1);
    for (int k = 0; k < 4; k++) begin
      if (k[0]) begin
        write_reg(REG_SEED_REAL, $urandom);
        write_reg(REG_SEED_IMAG, $urandom);
      end else begin
        write_reg(REG_SEED_REAL, 32'(rand_span(q(-1.0), q(0.5))));
        write_reg(REG_SEED_IMAG, 32'(rand_span(q(-1.0), q(1.0))));
      end
      write_reg(REG_MAX_ITER, $urandom_range(120, 20));
      send_random(40);
      drain();
    end

    // Mandelbrot at the largest limit: traps, slow escapes and far points only
    write_reg(REG_MODE, 32'd0);
    write_reg(REG_MAX_ITER, 32'd65535);
    send_point('0, '0);
    send_point(q(-1.0), q(0.1));
    send_point(q(0.26), '0);
    send_point(q(-0.75), q(0.05));
    repeat (8) begin
      send_point(($urandom_range(1, 0) != 0) ? rand_span(q(2.1), q(7.9))
                                              : rand_span(q(-7.9), q(-2.1)),
                 rand_span(q(-4.0), q(4.0)));
    end
    drain();

    repeat (40) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #25_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/etf_pkg.sv
rtl/core/etf_mul.sv
rtl/core/etf_core.sv
rtl/core/etf_cfg.sv
rtl/core/escape_time_fractal_iterator.sv
test/escape_time_checker.sv
test/tb.sv
